// ===== hw/rtl/sha256_pkg.sv =====
// Package with SHA-256 beat types, constants and round functions.
`default_nettype none
package sha256_pkg;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
  } out_beat_t;

  localparam logic OP_DATA   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [6:0] LEN_POS  = 7'd56;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sha256_message_hasher_top.sv =====
// Top level of the byte-serial SHA-256 message hasher.
//
// Usage: each input beat carries an operation and a data byte. A data beat
// (operation 0) appends its byte to the message; a finish beat (operation 1)
// pads the message, hashes the last block or two, and returns the digest as
// eight output beats, word 0 first, the eighth marked by last. The hasher
// then starts over from the initial hash value, so a new message may follow.
//
// Timing: a data beat that does not fill the block leaves ready high. The
// beat that fills a block starts the compression: a load of the sixteen
// block words, 64 rounds at one a cycle through a single round unit, and
// a final step that adds the working words into the hash words; ready is
// low throughout. A finish beat first writes padding one byte a cycle into
// the block buffer (64 minus the buffered byte count), then runs the
// compression; with 56 or more bytes buffered a second pass of 64 padding
// bytes and a second compression follow. The digest words then leave one
// a cycle while the receiver takes them. The message schedule lives in a
// 16-word sliding window, and the block buffer is a 16-word memory written
// a byte at a time and read one word per cycle.
//
// Reset (rst, synchronous) restores the initial hash value and clears the
// counts. If the receiver stalls, the current digest beat is held until
// taken and no input is accepted until the eighth digest beat leaves.
`default_nettype none
module sha256_message_hasher_top
  import sha256_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;  // accepting beats
  localparam logic [2:0] ST_LOAD = 3'd1;  // loading W[0..15] from the buffer
  localparam logic [2:0] ST_RND  = 3'd2;  // compression rounds
  localparam logic [2:0] ST_ADD  = 3'd3;  // fold working words into hash
  localparam logic [2:0] ST_PAD  = 3'd4;  // write padding bytes
  localparam logic [2:0] ST_OUT  = 3'd5;  // emit digest

  logic [2:0]  state;
  logic [31:0] hash [8];
  logic [31:0] work [8];
  logic [31:0] wwin [16];
  logic [31:0] mem [16];
  logic [6:0]  fill;
  logic [60:0] msg_bytes;
  logic [6:0]  step;        // round counter and pad / load pointer
  logic        finishing;   // pad flow active
  logic        final_blk;   // this compression is the last of a finish
  logic [63:0] bit_len;
  logic [2:0]  out_idx;
  logic [31:0] rd_word;

  // Block buffer: one byte written per cycle, one 32-bit word read.
  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_byte;
  logic [3:0]  rd_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
    end
    rd_word <= mem[rd_addr];
  end

  // Round unit.
  logic [31:0] w_cur, s0, s1, w_new, ch, mj, e1, a1, t1, t2;
  always_comb begin
    s0 = rotr(wwin[1], 7) ^ rotr(wwin[1], 18) ^ (wwin[1] >> 3);
    s1 = rotr(wwin[14], 17) ^ rotr(wwin[14], 19) ^ (wwin[14] >> 10);
    w_new = wwin[0] + s0 + wwin[9] + s1;
    w_cur = (step < 7'd16) ? wwin[step[3:0]] : w_new;
    ch = (work[4] & work[5]) ^ (~work[4] & work[6]);
    mj = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
    e1 = rotr(work[4], 6) ^ rotr(work[4], 11) ^ rotr(work[4], 25);
    a1 = rotr(work[0], 2) ^ rotr(work[0], 13) ^ rotr(work[0], 22);
    t1 = work[7] + e1 + ch + round_k(step[5:0]) + w_cur;
    t2 = a1 + mj;
  end

  logic in_fire, out_fire;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (state == ST_OUT);
  assign out_fire  = out_valid && out_ready;
  assign out_data.digest_word = hash[out_idx];
  assign out_data.word_index  = out_idx;
  assign out_data.last        = (out_idx == 3'd7);

  // Pad bytes: 0x80, zeros, then in the final block the length big-endian.
  // The extra block of a finish carries no pad byte, which fill 64 marks.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill[5:0];
    wr_byte = in_data.data_byte;
    rd_addr = step[3:0];
    if (in_fire && in_data.operation == OP_DATA) begin
      wr_en = 1'b1;
    end else if (state == ST_PAD) begin
      wr_en   = 1'b1;
      wr_addr = step[5:0];
      if (step[5:0] == fill[5:0] && !fill[6]) begin
        wr_byte = PAD_BYTE;
      end else if (step >= {1'b0, LEN_POS[5:0]} && final_blk) begin
        wr_byte = bit_len[8'(63 - 8 * int'(step[2:0])) -: 8];
      end else begin
        wr_byte = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      msg_bytes <= '0;
      step      <= '0;
      finishing <= 1'b0;
      final_blk <= 1'b0;
      out_idx   <= '0;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= init_h(3'(i));
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_data.operation == OP_DATA) begin
              msg_bytes <= msg_bytes + 61'd1;
              if (fill == 7'd63) begin
                fill  <= '0;
                step  <= '0;
                state <= ST_LOAD;
              end else begin
                fill <= fill + 7'd1;
              end
            end else begin
              bit_len   <= {msg_bytes, 3'b000};
              finishing <= 1'b1;
              // Length fits after the pad byte only when fill is below 56.
              final_blk <= (fill < LEN_POS);
              step      <= {1'b0, fill[5:0]};
              state     <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (step == 7'd63) begin
            step  <= '0;
            state <= ST_LOAD;
          end else begin
            step <= step + 7'd1;
          end
        end
        ST_LOAD: begin
          // Word step is read; its data lands in the next cycle.
          if (step != 7'd0) begin
            wwin[step[3:0] - 4'd1] <= rd_word;
          end
          if (step == 7'd16) begin
            step <= '0;
            for (int i = 0; i < 8; i++) begin
              work[i] <= hash[i];
            end
            state <= ST_RND;
          end else begin
            step <= step + 7'd1;
          end
        end
        ST_RND: begin
          if (step >= 7'd16) begin
            for (int i = 0; i < 15; i++) begin
              wwin[i] <= wwin[i + 1];
            end
            wwin[15] <= w_new;
          end
          work[7] <= work[6]; work[6] <= work[5]; work[5] <= work[4];
          work[4] <= work[3] + t1;
          work[3] <= work[2]; work[2] <= work[1]; work[1] <= work[0];
          work[0] <= t1 + t2;
          if (step == 7'd63) begin
            state <= ST_ADD;
          end
          step <= step + 7'd1;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + work[i];
          end
          step <= '0;
          if (!finishing) begin
            state <= ST_IDLE;
          end else if (final_blk) begin
            out_idx <= '0;
            state   <= ST_OUT;
          end else begin
            // Extra block: zeros then the length, no pad byte this time.
            final_blk <= 1'b1;
            fill      <= 7'd64;
            state     <= ST_PAD;
          end
        end
        ST_OUT: begin
          if (out_fire) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                hash[i] <= init_h(3'(i));
              end
              fill      <= '0;
              msg_bytes <= '0;
              finishing <= 1'b0;
              final_blk <= 1'b0;
              state     <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The block never takes input while a digest is pending.
  a_no_in_during_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input ready during digest");
  // Fill count stays inside the buffer while accepting bytes.
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> fill < 7'd64) else $error("fill count out of range");
  // Digest beats leave in order.
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    out_fire && !out_data.last |=> out_valid && out_idx == $past(out_idx) + 3'd1)
    else $error("digest index skipped");
  // Rounds always end with the hash update.
  a_rnd_add: assert property (@(posedge clk) disable iff (rst)
    state == ST_RND && step == 7'd63 |=> state == ST_ADD)
    else $error("round count mismatch");

endmodule
`default_nettype wire
